/* design/clft_pkg.sv */
// Shared constants, codes and request types for the fingerprint leaf table.
`timescale 1ns / 1ps
package clft_pkg;

  // Directory geometry
  localparam int unsigned DIR_SLOTS    = 256;
  localparam int unsigned PROBE_WINDOW = 4;
  localparam int unsigned SLOT_W       = $clog2(DIR_SLOTS);
  localparam int unsigned PROBE_CNT_W  = $clog2(PROBE_WINDOW + 1);

  // Field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned HASH_W   = 8;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned FP_W     = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned KEY_DEPTH = 2 ** POS_W;

  localparam logic [POS_W-1:0] LEAF_MAX_KEYS = 8'd255;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIND   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_MISS      = 3'd1,
    ST_DISPLACED = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4,
    ST_BAD_POS   = 3'd5
  } status_e;

  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [POS_W-1:0]  wpos;
    logic [FP_W-1:0]   wfp;
  } dir_req_t;

  typedef struct packed {
    logic             occ;
    logic [POS_W-1:0] pos;
    logic [FP_W-1:0]  fp;
  } dir_rsp_t;

  typedef struct packed {
    logic             re;
    logic [POS_W-1:0] raddr;
    logic             we;
    logic [POS_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
  } key_req_t;

endpackage

/* design/clft_dir.sv */
// Directory memory: slot position and fingerprint, with per-slot occupancy bits.
`timescale 1ns / 1ps
module clft_dir
  import clft_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dir_req_t req_i,
  output dir_rsp_t rsp_o
);

  logic [POS_W-1:0]     pos_mem [DIR_SLOTS];
  logic [FP_W-1:0]      fp_mem  [DIR_SLOTS];
  logic [DIR_SLOTS-1:0] occ_q;
  logic                 rd_occ_q;
  logic [POS_W-1:0]     rd_pos_q;
  logic [FP_W-1:0]      rd_fp_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      pos_mem[req_i.waddr] <= req_i.wpos;
      fp_mem[req_i.waddr]  <= req_i.wfp;
    end
    if (req_i.re) begin
      rd_pos_q <= pos_mem[req_i.raddr];
      rd_fp_q  <= fp_mem[req_i.raddr];
    end
  end

  // a slot is empty until first written; positions written are never zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      rd_occ_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        occ_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_occ_q <= occ_q[req_i.raddr];
      end
    end
  end

  assign rsp_o.occ = rd_occ_q;
  assign rsp_o.pos = rd_pos_q;
  assign rsp_o.fp  = rd_fp_q;

endmodule

/* design/clft_keys.sv */
// Dense key store: one write and one registered read per cycle.
`timescale 1ns / 1ps
module clft_keys
  import clft_pkg::*;
(
  input  logic             clk_i,
  input  key_req_t         req_i,
  output logic [KEY_W-1:0] rdata_o
);

  logic [KEY_W-1:0] key_mem [KEY_DEPTH];
  logic [KEY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      key_mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= key_mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/cuckoo_leaf_fingerprint_table.sv */
// Top level: request sequencer, result register and the two leaf memories.
`timescale 1ns / 1ps
// One cuckoo hash leaf: a directory of DIR_SLOTS slots (position + fingerprint)
// over a dense store of up to 255 keys. One request is handled at a time; the
// next is taken as soon as the result is in the output register. The directory
// has a single read port, so a find or insert walks the probe window one slot
// at a time (read in S_PROBE, checked in S_PCHK), with a full key compare
// through the key store port (S_KCHK) for each fingerprint match; a key hit
// ends the walk early. After the window S_DECIDE settles the result, and a
// displacing insert also passes through S_DISP. A read goes through S_RREAD;
// command 3 goes straight to S_DONE.
// Occupancy is held in flip-flops cleared by reset, so no clearing pass is needed.
module cuckoo_leaf_fingerprint_table
  import clft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // hash_byte[7:0], key[71:8], position[79:72]
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // index[7:0], count[15:8], out_key[79:16]
  output logic [2:0]  m_axis_tuser    // status[2:0]
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PROBE  = 8'b0000_0010,
    S_PCHK   = 8'b0000_0100,
    S_KCHK   = 8'b0000_1000,
    S_DECIDE = 8'b0001_0000,
    S_DISP   = 8'b0010_0000,
    S_RREAD  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e                 state_q, state_d;
  cmd_e                   cmd_q, cmd_d;
  logic [HASH_W-1:0]      slot_q, slot_d;
  logic [SLOT_W-1:0]      home_slot_q, home_slot_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [PROBE_CNT_W-1:0] probe_q, probe_d;
  logic                   empty_found_q, empty_found_d;
  logic [SLOT_W-1:0]      empty_slot_q, empty_slot_d;
  logic                   home_occ_q, home_occ_d;
  logic [POS_W-1:0]       home_pos_q, home_pos_d;
  logic [POS_W-1:0]       kidx_q, kidx_d;
  logic [POS_W-1:0]       count_q, count_d;
  status_e                res_status_q, res_status_d;
  logic [POS_W-1:0]       res_index_q, res_index_d;
  logic [KEY_W-1:0]       res_okey_q, res_okey_d;

  logic                   m_valid_q, m_valid_d;
  status_e                m_status_q, m_status_d;
  logic [POS_W-1:0]       m_index_q, m_index_d;
  logic [POS_W-1:0]       m_count_q, m_count_d;
  logic [KEY_W-1:0]       m_okey_q, m_okey_d;

  dir_req_t         dir_req;
  dir_rsp_t         dir_rsp;
  key_req_t         key_req;
  logic [KEY_W-1:0] key_rdata;

  logic              accept;
  logic              last_probe;
  logic              slot_high;
  logic [HASH_W-1:0] slot_next;
  logic [FP_W-1:0]   key_fp;

  clft_dir u_dir (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dir_req),
    .rsp_o  (dir_rsp)
  );

  clft_keys u_keys (
    .clk_i   (clk_i),
    .req_i   (key_req),
    .rdata_o (key_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign last_probe = (probe_q == PROBE_CNT_W'(PROBE_WINDOW - 1));
  assign slot_high  = ({1'b0, slot_q} >= (HASH_W + 1)'(DIR_SLOTS));
  assign slot_next  = (slot_q == HASH_W'(DIR_SLOTS - 1)) ? '0 : slot_q + 1'b1;
  assign key_fp     = key_q[FP_W:1];

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    slot_d        = slot_q;
    home_slot_d   = home_slot_q;
    key_d         = key_q;
    probe_d       = probe_q;
    empty_found_d = empty_found_q;
    empty_slot_d  = empty_slot_q;
    home_occ_d    = home_occ_q;
    home_pos_d    = home_pos_q;
    kidx_d        = kidx_q;
    count_d       = count_q;
    res_status_d  = res_status_q;
    res_index_d   = res_index_q;
    res_okey_d    = res_okey_q;
    dir_req       = '0;
    key_req       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d         = cmd_e'(s_axis_tuser);
          slot_d        = s_axis_tdata[7:0];
          key_d         = s_axis_tdata[71:8];
          probe_d       = '0;
          empty_found_d = 1'b0;
          home_occ_d    = 1'b0;
          res_okey_d    = '0;
          res_index_d   = '0;
          res_status_d  = ST_MISS;
          unique case (cmd_e'(s_axis_tuser))
            CMD_FIND, CMD_INSERT: state_d = S_PROBE;
            CMD_READ: begin
              res_index_d = s_axis_tdata[79:72];
              if (s_axis_tdata[79:72] < count_q) begin
                key_req.re    = 1'b1;
                key_req.raddr = s_axis_tdata[79:72];
                state_d       = S_RREAD;
              end else begin
                res_status_d = ST_BAD_POS;
                state_d      = S_DONE;
              end
            end
            CMD_NOP: state_d = S_DONE;
            default: state_d = S_DONE;
          endcase
        end
      end

      S_PROBE: begin
        // home slot is the hash byte modulo the directory size
        if (slot_high) begin
          slot_d = slot_q - HASH_W'(DIR_SLOTS);
        end else begin
          dir_req.re    = 1'b1;
          dir_req.raddr = slot_q[SLOT_W-1:0];
          if (probe_q == '0) begin
            home_slot_d = slot_q[SLOT_W-1:0];
          end
          state_d = S_PCHK;
        end
      end

      S_PCHK: begin
        if (probe_q == '0) begin
          home_occ_d = dir_rsp.occ;
          home_pos_d = dir_rsp.pos;
        end
        if (!dir_rsp.occ && !empty_found_q) begin
          empty_found_d = 1'b1;
          empty_slot_d  = slot_q[SLOT_W-1:0];
        end
        if (dir_rsp.occ && (dir_rsp.fp == key_fp)) begin
          kidx_d        = dir_rsp.pos - 1'b1;
          key_req.re    = 1'b1;
          key_req.raddr = dir_rsp.pos - 1'b1;
          state_d       = S_KCHK;
        end else if (last_probe) begin
          state_d = S_DECIDE;
        end else begin
          probe_d = probe_q + 1'b1;
          slot_d  = slot_next;
          state_d = S_PROBE;
        end
      end

      S_KCHK: begin
        // full compare ignores the hash-function indicator bit
        if (key_rdata[KEY_W-1:1] == key_q[KEY_W-1:1]) begin
          res_status_d = (cmd_q == CMD_INSERT) ? ST_DUPLICATE : ST_OK;
          res_index_d  = kidx_q;
          state_d      = S_DONE;
        end else if (last_probe) begin
          state_d = S_DECIDE;
        end else begin
          probe_d = probe_q + 1'b1;
          slot_d  = slot_next;
          state_d = S_PROBE;
        end
      end

      S_DECIDE: begin
        state_d = S_DONE;
        if (cmd_q == CMD_INSERT) begin
          if (empty_found_q && (count_q != LEAF_MAX_KEYS)) begin
            key_req.we    = 1'b1;
            key_req.waddr = count_q;
            key_req.wdata = key_q;
            dir_req.we    = 1'b1;
            dir_req.waddr = empty_slot_q;
            dir_req.wpos  = count_q + 1'b1;
            dir_req.wfp   = key_fp;
            count_d       = count_q + 1'b1;
            res_status_d  = ST_OK;
            res_index_d   = count_q;
          end else if (!home_occ_q) begin
            res_status_d = ST_FULL;
          end else begin
            key_req.re    = 1'b1;
            key_req.raddr = home_pos_q - 1'b1;
            state_d       = S_DISP;
          end
        end
      end

      S_DISP: begin
        key_req.we    = 1'b1;
        key_req.waddr = home_pos_q - 1'b1;
        key_req.wdata = key_q;
        dir_req.we    = 1'b1;
        dir_req.waddr = home_slot_q;
        dir_req.wpos  = home_pos_q;
        dir_req.wfp   = key_fp;
        res_status_d  = ST_DISPLACED;
        res_index_d   = home_pos_q - 1'b1;
        res_okey_d    = key_rdata;
        state_d       = S_DONE;
      end

      S_RREAD: begin
        res_status_d = ST_OK;
        res_okey_d   = key_rdata;
        state_d      = S_DONE;
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // output register: loaded from the finished result once free
  always_comb begin
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_status_d = m_status_q;
    m_index_d  = m_index_q;
    m_count_d  = m_count_q;
    m_okey_d   = m_okey_q;
    if ((state_q == S_DONE) && (!m_valid_q || m_axis_tready)) begin
      m_valid_d  = 1'b1;
      m_status_d = res_status_q;
      m_index_d  = res_index_q;
      m_count_d  = count_q;
      m_okey_d   = res_okey_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    slot_q        <= slot_d;
    home_slot_q   <= home_slot_d;
    key_q         <= key_d;
    probe_q       <= probe_d;
    empty_found_q <= empty_found_d;
    empty_slot_q  <= empty_slot_d;
    home_occ_q    <= home_occ_d;
    home_pos_q    <= home_pos_d;
    kidx_q        <= kidx_d;
    res_status_q  <= res_status_d;
    res_index_q   <= res_index_d;
    res_okey_q    <= res_okey_d;
    m_status_q    <= m_status_d;
    m_index_q     <= m_index_d;
    m_count_q     <= m_count_d;
    m_okey_q      <= m_okey_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_okey_q, m_count_q, m_index_q};
  assign m_axis_tuser  = m_status_q;

endmodule
